[design/nbtp_pkg.sv]
package nbtp_pkg;

  // Table and stack sizes
  localparam int unsigned POINT_SLOTS = 256;
  localparam int unsigned STACK_DEPTH = 64;

  localparam int unsigned TAB_AW = $clog2(POINT_SLOTS);
  localparam int unsigned STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int unsigned ID_W     = 8;
  localparam int unsigned TS_W     = 64;
  localparam int unsigned REC_W    = 7;
  localparam int unsigned NEST_W   = 7;

  typedef enum logic [1:0] {
    MODE_ENTER = 2'd0,
    MODE_EXIT  = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BAD_ID = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] point_id;
    logic [TS_W-1:0] timestamp;
  } prof_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   result_id;
    logic [TS_W-1:0]   inclusive_time;
    logic [TS_W-1:0]   exclusive_time;
    logic [TS_W-1:0]   hit_count;
    logic [NEST_W-1:0] nesting_level;
  } prof_out_t;

  // One row of the per-block totals table
  typedef struct packed {
    logic [TS_W-1:0]  incl;
    logic [TS_W-1:0]  excl;
    logic [TS_W-1:0]  hits;
    logic [REC_W-1:0] rec;
  } tab_entry_t;

  // One frame of the call stack
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] parent;
    logic [TS_W-1:0] start;
  } frame_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    clear;
    logic    accept;
    logic    push;
    logic    emit_zero;
    logic    enter_wr;
    logic    emit_tot;
    logic    pop;
    logic    par_wr;
    logic    slot_wr;
    status_e code;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic stk_full;
    logic stk_empty;
    logic id_bad;
    logic id_root;
  } dp_stat_t;

  function automatic logic [TAB_AW-1:0] id_to_addr(input logic [ID_W-1:0] id);
    logic [31:0] wide;
    wide = 32'(id);
    return wide[TAB_AW-1:0];
  endfunction

  function automatic logic id_out_of_range(input logic [ID_W-1:0] id);
    logic [31:0] wide;
    wide = 32'(id);
    return wide >= POINT_SLOTS;
  endfunction

  function automatic logic [NEST_W-1:0] level_out(input logic [LVL_W-1:0] lvl);
    logic [31:0] wide;
    wide = 32'(lvl);
    return wide[NEST_W-1:0];
  endfunction

endpackage

[design/nested_block_time_profiler.sv]
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------
// item     | start, busy        | item_i   (mode, point_id, timestamp)
// result   | result_valid_o     | result_o (status, result_id, totals, level)
//
// An item is taken when start is high and busy is low. Errors are decided in the
// accepting cycle; enter and read pass through their own state, exit through a
// stack read, a parent row update and a block row update through the single table write port.
// The result beat comes from an output register in the cycle after the last
// work cycle, while the next item may already be taken.
// After reset the table is cleared one row per cycle; busy stays high until the
// last row is cleared. The receiver cannot stall; each beat lasts one cycle.
module nested_block_time_profiler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  nbtp_pkg::prof_in_t  item_i,
  output nbtp_pkg::prof_out_t result_o,
  output logic                result_valid_o
);
  import nbtp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nbtp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (item_i.mode),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  nbtp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

endmodule

[design/nbtp_ram.sv]
module nbtp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/nbtp_ctrl.sv]
module nbtp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         mode_i,
  input  nbtp_pkg::dp_stat_t stat_i,
  output nbtp_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);
  import nbtp_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_ENTER  = 7'b0000100,
    S_READ   = 7'b0001000,
    S_POP    = 7'b0010000,
    S_PARENT = 7'b0100000,
    S_SLOT   = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  dp_cmd_t     cmd;

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    cmd      = '0;
    cmd.code = ST_OK;
    unique case (state_q)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd.accept = 1'b1;
          if (mode_i == MODE_ENTER) begin
            if (stat_i.id_bad || stat_i.id_root) begin
              cmd.emit_zero = 1'b1;
              cmd.code      = ST_BAD_ID;
            end else if (stat_i.stk_full) begin
              cmd.code = ST_FULL;
              state_d  = S_READ;
            end else begin
              cmd.push = 1'b1;
              state_d  = S_ENTER;
            end
          end else if (mode_i == MODE_EXIT) begin
            if (stat_i.stk_empty) begin
              cmd.emit_zero = 1'b1;
              cmd.code      = ST_EMPTY;
            end else begin
              state_d = S_POP;
            end
          end else begin
            // read, and the spare mode code acts as read
            if (stat_i.id_bad) begin
              cmd.emit_zero = 1'b1;
              cmd.code      = ST_BAD_ID;
            end else begin
              state_d = S_READ;
            end
          end
        end
      end
      S_ENTER: begin
        cmd.enter_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_READ: begin
        cmd.emit_tot = 1'b1;
        state_d      = S_IDLE;
      end
      S_POP: begin
        cmd.pop = 1'b1;
        state_d = S_PARENT;
      end
      S_PARENT: begin
        cmd.par_wr = 1'b1;
        state_d    = S_SLOT;
      end
      S_SLOT: begin
        cmd.slot_wr = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

`ifndef SYNTH
  a_exit_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (state_q == S_PARENT))
    else $error("exit sequence broken after pop");

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !stat_i.clr_last) |=> (state_q == S_CLEAR))
    else $error("clearing pass left early");
`endif

endmodule

[design/nbtp_dp.sv]
module nbtp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nbtp_pkg::prof_in_t  item_i,
  input  nbtp_pkg::dp_cmd_t   cmd_i,
  output nbtp_pkg::dp_stat_t  stat_o,
  output nbtp_pkg::prof_out_t result_o,
  output logic                result_valid_o
);
  import nbtp_pkg::*;

  prof_in_t         item_q;
  status_e          code_q;
  logic [LVL_W-1:0] level_q, level_d, level_dec;
  logic [ID_W-1:0]  parent_q, parent_d;
  logic [TAB_AW-1:0] clr_q;
  logic [ID_W-1:0]  slot_q, par_q;
  logic [TS_W-1:0]  elapsed_q;
  tab_entry_t       par_ent_q;
  prof_out_t        res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr;
  tab_entry_t        tab_wdata, tab_rdata;
  logic              stk_we;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;
  frame_t            stk_wdata, stk_rdata;

  tab_entry_t       enter_ent, par_new, slot_ent, slot_new;
  logic [REC_W-1:0] rec_dec;

  // Status toward the controller
  always_comb begin
    stat_o.clr_last  = (clr_q == TAB_AW'(POINT_SLOTS - 1));
    stat_o.stk_full  = (level_q == LVL_W'(STACK_DEPTH));
    stat_o.stk_empty = (level_q == '0);
    stat_o.id_bad    = id_out_of_range(item_i.point_id);
    stat_o.id_root   = (item_i.point_id == '0);
  end

  assign level_dec = level_q - LVL_W'(1);

  // Frame stack port
  assign stk_we           = cmd_i.push;
  assign stk_waddr        = level_q[STK_AW-1:0];
  assign stk_wdata.id     = item_i.point_id;
  assign stk_wdata.parent = parent_q;
  assign stk_wdata.start  = item_i.timestamp;
  assign stk_raddr        = level_dec[STK_AW-1:0];

  nbtp_ram #(
    .WIDTH($bits(frame_t)),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // Table read address: parent on pop, slot during the parent update, else the item
  always_comb begin
    if (cmd_i.pop) begin
      tab_raddr = id_to_addr(stk_rdata.parent);
    end else if (cmd_i.par_wr) begin
      tab_raddr = id_to_addr(slot_q);
    end else begin
      tab_raddr = id_to_addr(item_i.point_id);
    end
  end

  // Row updates
  always_comb begin
    enter_ent     = tab_rdata;
    enter_ent.rec = tab_rdata.rec + REC_W'(1);

    par_new      = tab_rdata;
    par_new.excl = tab_rdata.excl - elapsed_q;

    // forward the parent row when the slot is its own parent
    slot_ent      = (slot_q == par_q) ? par_ent_q : tab_rdata;
    rec_dec       = slot_ent.rec - REC_W'(1);
    slot_new.rec  = rec_dec;
    slot_new.hits = slot_ent.hits + TS_W'(1);
    slot_new.excl = slot_ent.excl + elapsed_q;
    slot_new.incl = (rec_dec == '0) ? (slot_ent.incl + elapsed_q) : slot_ent.incl;
  end

  // Table write port
  always_comb begin
    tab_we    = 1'b1;
    tab_waddr = clr_q;
    tab_wdata = '0;
    priority if (cmd_i.clear) begin
      tab_waddr = clr_q;
      tab_wdata = '0;
    end else if (cmd_i.enter_wr) begin
      tab_waddr = id_to_addr(item_q.point_id);
      tab_wdata = enter_ent;
    end else if (cmd_i.par_wr) begin
      tab_waddr = id_to_addr(par_q);
      tab_wdata = par_new;
    end else if (cmd_i.slot_wr) begin
      tab_waddr = id_to_addr(slot_q);
      tab_wdata = slot_new;
    end else begin
      tab_we = 1'b0;
    end
  end

  nbtp_ram #(
    .WIDTH($bits(tab_entry_t)),
    .DEPTH(POINT_SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(tab_waddr),
    .wdata_i(tab_wdata),
    .raddr_i(tab_raddr),
    .rdata_o(tab_rdata)
  );

  // Stack level and current parent
  always_comb begin
    level_d  = level_q;
    parent_d = parent_q;
    if (cmd_i.push) begin
      level_d  = level_q + LVL_W'(1);
      parent_d = item_i.point_id;
    end else if (cmd_i.pop) begin
      level_d  = level_dec;
      parent_d = stk_rdata.parent;
    end
  end

  // Result beat
  always_comb begin
    res_valid_d = cmd_i.emit_zero | cmd_i.enter_wr | cmd_i.emit_tot | cmd_i.slot_wr;
    res_d                = '0;
    res_d.nesting_level  = level_out(level_q);
    priority if (cmd_i.emit_zero) begin
      res_d.status = cmd_i.code;
    end else if (cmd_i.enter_wr) begin
      res_d.status         = ST_OK;
      res_d.result_id      = item_q.point_id;
      res_d.inclusive_time = tab_rdata.incl;
      res_d.exclusive_time = tab_rdata.excl;
      res_d.hit_count      = tab_rdata.hits;
    end else if (cmd_i.emit_tot) begin
      res_d.status         = code_q;
      res_d.result_id      = item_q.point_id;
      res_d.inclusive_time = tab_rdata.incl;
      res_d.exclusive_time = tab_rdata.excl;
      res_d.hit_count      = tab_rdata.hits;
    end else if (cmd_i.slot_wr) begin
      res_d.status         = ST_OK;
      res_d.result_id      = slot_q;
      res_d.inclusive_time = slot_new.incl;
      res_d.exclusive_time = slot_new.excl;
      res_d.hit_count      = slot_new.hits;
    end else begin
      res_d = res_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      parent_q    <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      parent_q    <= parent_d;
      res_valid_q <= res_valid_d;
      if (cmd_i.clear) begin
        clr_q <= clr_q + TAB_AW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.accept) begin
      item_q <= item_i;
      code_q <= cmd_i.code;
    end
    if (cmd_i.pop) begin
      slot_q    <= stk_rdata.id;
      par_q     <= stk_rdata.parent;
      elapsed_q <= item_q.timestamp - stk_rdata.start;
    end
    if (cmd_i.par_wr) begin
      par_ent_q <= par_new;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(level_q) <= STACK_DEPTH)
    else $error("stack level beyond depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !stat_o.stk_full)
    else $error("push on a full stack");

  a_slot_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.slot_wr |=> (res_valid_q && res_q.status == ST_OK))
    else $error("exit finished without a result beat");
`endif

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  import nbtp_pkg::*;

  // Spare mode code, decoded by the block as a read
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1700;

  typedef struct {
    prof_in_t    beat;
    int unsigned gap;
    bit          drain;
  } probe_event_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  prof_in_t  item = '0;
  prof_out_t result;
  logic      result_valid;

  nested_block_time_profiler u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_o       (result),
    .result_valid_o (result_valid)
  );

  always #2 clk = ~clk;

  // Predicted profiler state
  logic [TS_W-1:0]  excl_tot  [POINT_SLOTS];
  logic [TS_W-1:0]  incl_tot  [POINT_SLOTS];
  logic [TS_W-1:0]  hit_tot   [POINT_SLOTS];
  logic [REC_W-1:0] rec_cnt   [POINT_SLOTS];
  logic [ID_W-1:0]  frm_id    [STACK_DEPTH];
  logic [ID_W-1:0]  frm_par   [STACK_DEPTH];
  logic [TS_W-1:0]  frm_start [STACK_DEPTH];
  int unsigned      depth;
  logic [ID_W-1:0]  cur_parent;

  probe_event_t event_q[$];
  prof_out_t    totals_due[$];
  int unsigned  n_pred = 0;
  int unsigned  n_seen = 0;
  int unsigned  errors = 0;
  bit           staged = 1'b0;
  probe_event_t cur;
  int unsigned  wait_left;

  // Coverage tallies
  int unsigned  n_ok = 0, n_full = 0, n_empty = 0, n_bad = 0, deepest = 0;

  // Stimulus generator state
  int           gen_depth = 0;
  int unsigned  gen_count = 0;
  logic [TS_W-1:0] gen_ts = '0;
  bit           drain_next = 1'b0;
  int unsigned  stretch_left = 0;
  bit           calm = 1'b0;

  // Advance the profiler state by one event and return its result beat
  function automatic prof_out_t profile_step(input prof_in_t it);
    prof_out_t       r;
    logic [ID_W-1:0] id, slot, par;
    logic [TS_W-1:0] elapsed;
    bit              show;
    r    = '0;
    id   = it.point_id;
    slot = '0;
    show = 1'b1;
    case (it.mode)
      MODE_ENTER: begin
        if (id == 0 || 32'(id) >= POINT_SLOTS) begin
          r.status = ST_BAD_ID;
          show = 1'b0;
        end else if (depth >= STACK_DEPTH) begin
          r.status = ST_FULL;
          slot = id;
        end else begin
          frm_id[depth]    = id;
          frm_par[depth]   = cur_parent;
          frm_start[depth] = it.timestamp;
          depth++;
          rec_cnt[id] = rec_cnt[id] + 1'b1;
          cur_parent  = id;
          r.status = ST_OK;
          slot = id;
        end
      end
      MODE_EXIT: begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
          show = 1'b0;
        end else begin
          depth--;
          slot    = frm_id[depth];
          par     = frm_par[depth];
          elapsed = it.timestamp - frm_start[depth];
          cur_parent = par;
          excl_tot[par] = excl_tot[par] - elapsed;
          rec_cnt[slot] = rec_cnt[slot] - 1'b1;
          hit_tot[slot] = hit_tot[slot] + 1;
          excl_tot[slot] = excl_tot[slot] + elapsed;
          if (rec_cnt[slot] == 0) incl_tot[slot] = incl_tot[slot] + elapsed;
          r.status = ST_OK;
        end
      end
      default: begin
        if (32'(id) >= POINT_SLOTS) begin
          r.status = ST_BAD_ID;
          show = 1'b0;
        end else begin
          r.status = ST_OK;
          slot = id;
        end
      end
    endcase
    r.result_id = slot;
    if (show && 32'(slot) < POINT_SLOTS) begin
      r.inclusive_time = incl_tot[slot];
      r.exclusive_time = excl_tot[slot];
      r.hit_count      = hit_tot[slot];
    end
    r.nesting_level = depth[NEST_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TS_W-1:0] want,
                             input logic [TS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Queue one event with its idle gap; gaps come in idle and busy stretches
  task automatic add_item(input logic [1:0] m, input logic [ID_W-1:0] id,
                          input logic [TS_W-1:0] ts);
    probe_event_t ev;
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(20, 80);
      calm = ($urandom_range(0, 3) == 0);
    end
    stretch_left--;
    ev.beat.mode      = m;
    ev.beat.point_id  = id;
    ev.beat.timestamp = ts;
    ev.gap   = calm ? 0 : $urandom_range(0, 12);
    ev.drain = drain_next;
    drain_next = 1'b0;
    event_q.push_back(ev);
    gen_count++;
    if (m == MODE_ENTER && id != 0 && gen_depth < STACK_DEPTH) gen_depth++;
    else if (m == MODE_EXIT && gen_depth > 0) gen_depth--;
  endtask

  function automatic logic [TS_W-1:0] tick();
    if ($urandom_range(0, 19) == 0) gen_ts = gen_ts + {$urandom, $urandom};
    else gen_ts = gen_ts + $urandom_range(1, 60);
    return gen_ts;
  endfunction

  // Mostly a few hot blocks so that recursion shows up
  function automatic logic [ID_W-1:0] pick_block();
    if ($urandom_range(0, 9) < 7) return ID_W'($urandom_range(1, 12));
    return ID_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [TS_W-1:0] any_ts();
    return {$urandom, $urandom};
  endfunction

  // Well-formed call nest with random content, closed at the end
  task automatic call_walk();
    int unsigned steps, s;
    steps = $urandom_range(8, 40);
    for (s = 0; s < steps; s++) begin
      if (gen_depth == 0 || (gen_depth < 24 && $urandom_range(0, 1) == 0))
        add_item(MODE_ENTER, pick_block(), tick());
      else if ($urandom_range(0, 4) != 0)
        add_item(MODE_EXIT, ID_W'($urandom), tick());
      else
        add_item(MODE_READ, ID_W'($urandom_range(0, 255)), any_ts());
    end
    while (gen_depth > 0) add_item(MODE_EXIT, ID_W'($urandom), tick());
  endtask

  // Fill the stack, push past it, then unwind past empty
  task automatic deep_dive();
    while (gen_depth < STACK_DEPTH) add_item(MODE_ENTER, pick_block(), tick());
    repeat ($urandom_range(1, 3)) add_item(MODE_ENTER, pick_block(), tick());
    add_item(MODE_READ, pick_block(), any_ts());
    while (gen_depth > 0) add_item(MODE_EXIT, ID_W'($urandom), tick());
    repeat ($urandom_range(1, 2)) add_item(MODE_EXIT, ID_W'($urandom), tick());
  endtask

  // Driver: record accepted beats, then present the next pending event
  always @(posedge clk) begin
    prof_out_t due;
    logic      raise;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      raise = start;
      if (start && !busy) begin
        due = profile_step(item);
        totals_due.push_back(due);
        n_pred++;
        raise = 1'b0;
      end
      if (!raise) begin
        if (!staged && event_q.size() > 0) begin
          cur = event_q.pop_front();
          staged = 1'b1;
          wait_left = cur.gap;
        end
        if (staged) begin
          if (wait_left > 0) begin
            wait_left--;
          end else if (!cur.drain || n_pred == n_seen) begin
            item <= cur.beat;
            raise = 1'b1;
            staged = 1'b0;
          end
        end
      end
      start <= raise;
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    prof_out_t want;
    if (rst_n && result_valid) begin
      if (totals_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, result);
        errors++;
      end else begin
        want = totals_due.pop_front();
        check_field("status", 64'(want.status), 64'(result.status));
        check_field("result_id", 64'(want.result_id), 64'(result.result_id));
        check_field("inclusive_time", want.inclusive_time, result.inclusive_time);
        check_field("exclusive_time", want.exclusive_time, result.exclusive_time);
        check_field("hit_count", want.hit_count, result.hit_count);
        check_field("nesting_level", 64'(want.nesting_level), 64'(result.nesting_level));
        case (want.status)
          ST_OK:    n_ok++;
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          default:  n_bad++;
        endcase
        if (want.nesting_level > deepest) deepest = want.nesting_level;
        n_seen <= n_seen + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    for (int unsigned i = 0; i < POINT_SLOTS; i++) begin
      excl_tot[i] = '0;
      incl_tot[i] = '0;
      hit_tot[i]  = '0;
      rec_cnt[i]  = '0;
    end
    depth = 0;
    cur_parent = '0;

    // Directed: error cases, extremes, wrap and recursion
    add_item(MODE_EXIT, 8'h00, 64'h0);
    add_item(MODE_READ, 8'h00, 64'h0);
    add_item(MODE_READ, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(MODE_SPARE, 8'h07, 64'h0);
    add_item(MODE_ENTER, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(MODE_ENTER, 8'hFF, 64'hFFFF_FFFF_FFFF_FFF0);
    add_item(MODE_ENTER, 8'h01, 64'h10);
    add_item(MODE_EXIT, 8'h00, 64'h5);
    add_item(MODE_EXIT, 8'hFF, 64'h20);
    add_item(MODE_READ, 8'hFF, 64'h0);
    add_item(MODE_READ, 8'h01, 64'h0);
    add_item(MODE_READ, 8'h00, 64'h0);
    add_item(MODE_ENTER, 8'h09, 64'd100);
    add_item(MODE_ENTER, 8'h09, 64'd110);
    add_item(MODE_ENTER, 8'h03, 64'd115);
    add_item(MODE_EXIT, 8'h00, 64'd130);
    add_item(MODE_EXIT, 8'h00, 64'd150);
    add_item(MODE_EXIT, 8'h00, 64'd200);
    add_item(MODE_READ, 8'h09, 64'h0);
    add_item(MODE_READ, 8'h03, 64'h0);
    add_item(MODE_ENTER, 8'h80, 64'h0);
    add_item(MODE_EXIT, 8'h7F, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(MODE_READ, 8'h80, 64'h0);
    add_item(MODE_EXIT, 8'hAA, 64'h0);
    gen_ts = 64'd1000;

    // Random: mostly call nests, some stack fills, some noise
    drain_next = 1'b1;
    gen_count = 0;
    while (gen_count < RANDOM_ITEMS) begin
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        deep_dive();
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 6))
          add_item(2'($urandom_range(0, 3)), ID_W'($urandom), any_ts());
      end else begin
        call_walk();
      end
      if ($urandom_range(0, 11) == 0) drain_next = 1'b1;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every event is taken and every result is back
    do @(negedge clk); while (event_q.size() != 0 || staged || start);
    do @(negedge clk); while (n_seen != n_pred);
    repeat (16) @(negedge clk);
    if (totals_due.size() != 0) begin
      $display("%0t: %0d result beats missing, expected %0d more, got none",
               $time, totals_due.size(), totals_due.size());
      errors += totals_due.size();
    end
    $display("covered %0d result beats: %0d ok, %0d stack full, %0d stack empty, %0d bad id",
             n_seen, n_ok, n_full, n_empty, n_bad);
    $display("deepest nesting reached %0d of %0d frames", deepest, STACK_DEPTH);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
